// ===== sv/eold_pkg.sv =====
// Package for the EMG onset and lift detector.
// Holds the field widths, register indexes, reset values and the config struct.
// No dependencies.
package eold_pkg;

  // Level and register widths
  localparam int unsigned LEVEL_W    = 20;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = LEVEL_W;

  // Default datapath parameters
  localparam int unsigned DEF_SAMPLE_BITS = 12;
  localparam int unsigned DEF_FRAC_BITS   = 8;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(59578);
  localparam logic [RUN_W-1:0]   ENTER_RST = RUN_W'(3);
  localparam logic [RUN_W-1:0]   EXIT_RST  = RUN_W'(6);
  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(12);

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 3'd0,
    REG_ON_THR    = 3'd1,
    REG_OFF_THR   = 3'd2,
    REG_LIFT_THR  = 3'd3,
    REG_ENTER_CNT = 3'd4,
    REG_EXIT_CNT  = 3'd5,
    REG_LIFT_HOLD = 3'd6
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [LEVEL_W-1:0] on_thr;
    logic [LEVEL_W-1:0] off_thr;
    logic [LEVEL_W-1:0] lift_thr;
    logic [RUN_W-1:0]   enter_cnt;
    logic [RUN_W-1:0]   exit_cnt;
    logic [HOLD_W-1:0]  lift_hold;
  } cfg_t;

endpackage

// ===== sv/eold_smooth.sv =====
// Exponential smoother update for one sample, pure combinational.
// Depends on eold_pkg for the level and alpha widths.
module eold_smooth import eold_pkg::*; (
  input  logic               primed_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [LEVEL_W-1:0] x_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic [LEVEL_W-1:0] level_o
);

  localparam int unsigned DiffW = LEVEL_W + 1;
  localparam int unsigned ProdW = ALPHA_W + 1 + DiffW;
  localparam int unsigned AccW  = ProdW + 1;

  logic signed [DiffW-1:0]   diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW-1:0]    acc;

  // a*L + (1-a)*x rewritten as x + a*(L - x): one signed multiply
  always_comb begin
    diff    = $signed({1'b0, level_i}) - $signed({1'b0, x_i});
    alpha_s = $signed({1'b0, alpha_i});
    prod    = alpha_s * diff;
    acc     = $signed({{(AccW-LEVEL_W-ALPHA_W){1'b0}}, x_i, {ALPHA_W{1'b0}}})
            + AccW'(prod)
            + $signed(AccW'(1) <<< (ALPHA_W - 1));
    // result never exceeds the larger of level and x, so it fits
    if (primed_i) begin
      level_o = acc[ALPHA_W +: LEVEL_W];
    end else begin
      level_o = x_i;
    end
  end

endmodule

// ===== sv/eold_detect.sv =====
// Activity hysteresis/debounce and lift hold detectors.
// Depends on eold_pkg for widths and the config struct.
module eold_detect import eold_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  cfg_t               cfg_i,
  output logic               active_o,
  output logic               lift_o
);

  logic              active_q, active_d;
  logic [RUN_W-1:0]  enter_run_q, enter_run_d;
  logic [RUN_W-1:0]  exit_run_q, exit_run_d;
  logic              lift_q, lift_d;
  logic              armed_q, armed_d;
  logic [HOLD_W-1:0] lift_run_q, lift_run_d;
  logic [RUN_W-1:0]  enter_inc, exit_inc;

  // Activity flag: count qualifying samples in the current state
  always_comb begin
    active_d    = active_q;
    enter_run_d = enter_run_q;
    exit_run_d  = exit_run_q;
    enter_inc   = enter_run_q + RUN_W'(1);
    exit_inc    = exit_run_q + RUN_W'(1);
    if (!active_q) begin
      if (level_i >= cfg_i.on_thr) begin
        enter_run_d = enter_inc;
        if (enter_inc >= cfg_i.enter_cnt) begin
          active_d    = 1'b1;
          enter_run_d = '0;
        end
      end else begin
        enter_run_d = '0;
      end
    end else begin
      if (level_i <= cfg_i.off_thr) begin
        exit_run_d = exit_inc;
        if (exit_inc >= cfg_i.exit_cnt) begin
          active_d   = 1'b0;
          exit_run_d = '0;
        end
      end else begin
        exit_run_d = '0;
      end
    end
  end

  // Lift flag: arm on first crossing, then count held samples (saturating)
  always_comb begin
    lift_d     = lift_q;
    armed_d    = armed_q;
    lift_run_d = lift_run_q;
    if (level_i >= cfg_i.lift_thr) begin
      if (!lift_q) begin
        if (!armed_q) begin
          armed_d    = 1'b1;
          lift_run_d = '0;
        end else if (lift_run_q != {HOLD_W{1'b1}}) begin
          lift_run_d = lift_run_q + HOLD_W'(1);
        end
        if (lift_run_d >= cfg_i.lift_hold) begin
          lift_d = 1'b1;
        end
      end
    end else begin
      lift_d     = 1'b0;
      armed_d    = 1'b0;
      lift_run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      enter_run_q <= '0;
      exit_run_q  <= '0;
      lift_q      <= 1'b0;
      armed_q     <= 1'b0;
      lift_run_q  <= '0;
    end else if (en_i) begin
      active_q    <= active_d;
      enter_run_q <= enter_run_d;
      exit_run_q  <= exit_run_d;
      lift_q      <= lift_d;
      armed_q     <= armed_d;
      lift_run_q  <= lift_run_d;
    end
  end

  assign active_o = active_q;
  assign lift_o   = lift_q;

endmodule

// ===== sv/emg_onset_lift_detector_top.sv =====
// Top level of the EMG onset and lift detector: handshakes, config registers,
// sample register and smoother state. Depends on eold_pkg, eold_smooth, eold_detect.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | sample_i
//  out     | source    | out_valid_o / out_stall_i| smoothed_o, is_active_o, is_lift_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A request passes the sample register (scaling), then the smoother multiply and
// detector update into the result registers. One request is taken every cycle while
// the output is not stalled; the smoother feedback runs through the level register.
// The smoother level and flags are the result registers; they hold while a valid result
// sees out_stall_i high, and a full sample register then holds and raises in_stall_o.
// Reset (rst_ni low, asynchronous) clears state but sample data, loads register defaults.
module emg_onset_lift_detector_top import eold_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    smoothed_o,
  output logic                  is_active_o,
  output logic                  is_lift_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ScaleW = SAMPLE_BITS + FRAC_BITS + LEVEL_W;

  cfg_t               cfg_q;
  logic               s1_valid_q;
  logic [LEVEL_W-1:0] x_q, x_d;
  logic [ScaleW-1:0]  scaled;
  logic               out_valid_q;
  logic               primed_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               adv;
  logic               in_take;

  // Config writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= ALPHA_RST;
      cfg_q.on_thr    <= '0;
      cfg_q.off_thr   <= '0;
      cfg_q.lift_thr  <= '0;
      cfg_q.enter_cnt <= ENTER_RST;
      cfg_q.exit_cnt  <= EXIT_RST;
      cfg_q.lift_hold <= HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ALPHA:     cfg_q.alpha     <= cfg_data_i[ALPHA_W-1:0];
        REG_ON_THR:    cfg_q.on_thr    <= cfg_data_i[LEVEL_W-1:0];
        REG_OFF_THR:   cfg_q.off_thr   <= cfg_data_i[LEVEL_W-1:0];
        REG_LIFT_THR:  cfg_q.lift_thr  <= cfg_data_i[LEVEL_W-1:0];
        REG_ENTER_CNT: cfg_q.enter_cnt <= cfg_data_i[RUN_W-1:0];
        REG_EXIT_CNT:  cfg_q.exit_cnt  <= cfg_data_i[RUN_W-1:0];
        REG_LIFT_HOLD: cfg_q.lift_hold <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: result registers advance when empty or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Scale sample to Q.FRAC_BITS, saturate to the level width
  always_comb begin
    scaled = ScaleW'(sample_i) << FRAC_BITS;
    if (|scaled[ScaleW-1:LEVEL_W]) begin
      x_d = {LEVEL_W{1'b1}};
    end else begin
      x_d = scaled[LEVEL_W-1:0];
    end
  end

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q <= x_d;
    end
  end

  // Smoother update
  eold_smooth u_smooth (
    .primed_i (primed_q),
    .level_i  (level_q),
    .x_i      (x_q),
    .alpha_i  (cfg_q.alpha),
    .level_o  (level_d)
  );

  // Smoother state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
      level_q     <= '0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        primed_q <= 1'b1;
        level_q  <= level_d;
      end
    end
  end

  // Activity and lift detectors
  eold_detect u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv && s1_valid_q),
    .level_i  (level_d),
    .cfg_i    (cfg_q),
    .active_o (is_active_o),
    .lift_o   (is_lift_o)
  );

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = level_q;

  // A held result must also hold back the sample register
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("sample register not stalled behind a held result");

  // Any delivered result comes after the smoother is loaded
  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> primed_q)
    else $error("result valid before smoother primed");

  // Lift flag on a fresh result implies level at or above the lift level
  a_lift_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> (!is_lift_o || (smoothed_o >= $past(cfg_q.lift_thr))))
    else $error("lift flag set below lift level");

endmodule
